### sv/kq_pkg.sv
package kq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned RoundW      = 10;
  localparam int unsigned MaxRounds   = 1 << RoundW;
  localparam int unsigned RoundsPerSt = 4;
  localparam logic [31:0] Nlf         = 32'h3A5C742E;
  localparam logic [RoundW-1:0] FullRounds = 10'd528;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } kq_cmd_e;

  typedef enum logic {
    REG_CIPHER_KEY  = 1'b0,
    REG_ROUND_COUNT = 1'b1
  } kq_reg_e;

  typedef struct packed {
    logic             valid;
    kq_cmd_e          command;
    logic [DataW-1:0] data;
  } kq_word_t;

  function automatic logic [DataW-1:0] enc_round(logic [DataW-1:0] x, logic kb);
    logic [4:0] sel;
    logic       fb;
    sel = {x[31], x[26], x[20], x[9], x[1]};
    fb  = x[0] ^ x[16] ^ kb ^ Nlf[sel];
    return {fb, x[DataW-1:1]};
  endfunction

  function automatic logic [DataW-1:0] dec_round(logic [DataW-1:0] x, logic kb);
    logic [4:0] sel;
    logic       fb;
    sel = {x[30], x[25], x[19], x[8], x[0]};
    fb  = x[31] ^ x[15] ^ kb ^ Nlf[sel];
    return {x[DataW-2:0], fb};
  endfunction

endpackage

### sv/kq_in_if.sv
interface kq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [kq_pkg::DataW-1:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink (input valid, input command, input data_in, output ready);
endinterface

### sv/kq_out_if.sv
interface kq_out_if;
  logic                     valid;
  logic                     ready;
  logic [kq_pkg::DataW-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

### sv/keeloq_cipher_core_top.sv
// channel  dir  fields               accepted when
// in_if    in   command, data_in     in_if.valid && in_if.ready
// out_if   out  data_out             out_if.valid && out_if.ready
// cfg      in   cfg_idx_i, cfg_data_i cfg_we_i (0 key, 1 round count)
//
// Pipeline of MaxRounds/RoundsPerSt stages, RoundsPerSt rounds per stage;
// words pass each stage register in order; one per cycle unless stalled.
// Reset clears valid bits and loads key 0, round count 528.
// The whole pipeline holds while the output word waits on out_if.ready.
module keeloq_cipher_core_top #(
  parameter int unsigned Rps = kq_pkg::RoundsPerSt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [kq_pkg::KeyW-1:0]   cfg_data_i,
  kq_in_if.sink                     in_if,
  kq_out_if.source                  out_if
);

  localparam int unsigned Stages = (kq_pkg::MaxRounds + Rps - 1) / Rps;

  logic [kq_pkg::KeyW-1:0]   key_q;
  logic [kq_pkg::RoundW-1:0] round_count_q;
  logic                      en;
  kq_pkg::kq_word_t          stage_w [Stages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= '0;
      round_count_q <= kq_pkg::FullRounds;
    end else if (cfg_we_i) begin
      case (kq_pkg::kq_reg_e'(cfg_idx_i))
        kq_pkg::REG_CIPHER_KEY:  key_q         <= cfg_data_i;
        kq_pkg::REG_ROUND_COUNT: round_count_q <= cfg_data_i[kq_pkg::RoundW-1:0];
        default: ;
      endcase
    end
  end

  assign en = out_if.ready || !stage_w[Stages].valid;

  assign stage_w[0] = '{valid:   in_if.valid,
                        command: kq_pkg::kq_cmd_e'(in_if.command),
                        data:    in_if.data_in};

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    kq_round_stage #(.Base(s * Rps), .Rps(Rps)) u_stage (
      .clk_i,
      .rst_ni,
      .en_i          (en),
      .key_i         (key_q),
      .round_count_i (round_count_q),
      .word_i        (stage_w[s]),
      .word_o        (stage_w[s+1])
    );
  end

  assign in_if.ready     = en;
  assign out_if.valid    = stage_w[Stages].valid;
  assign out_if.data_out = stage_w[Stages].data;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (out_if.ready || !out_if.valid))
    else $error("ready does not follow output stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> stage_w[1].valid)
    else $error("accepted word lost at first stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(stage_w[1].valid) && $stable(stage_w[1].data)))
    else $error("first stage moved during stall");

endmodule

### sv/kq_round_stage.sv
module kq_round_stage #(
  parameter int unsigned Base = 0,
  parameter int unsigned Rps  = kq_pkg::RoundsPerSt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [kq_pkg::KeyW-1:0]       key_i,
  input  logic [kq_pkg::RoundW-1:0]     round_count_i,
  input  kq_pkg::kq_word_t              word_i,
  output kq_pkg::kq_word_t              word_o
);

  kq_pkg::kq_word_t         word_d;
  logic                     valid_q;
  kq_pkg::kq_cmd_e          command_q;
  logic [kq_pkg::DataW-1:0] data_q;

  always_comb begin
    logic [kq_pkg::DataW-1:0] x;
    logic [5:0]               kidx;
    x    = word_i.data;
    kidx = '0;
    for (int unsigned j = 0; j < Rps; j++) begin
      if ((Base + j) < int'({1'b0, round_count_i})) begin
        if (word_i.command == kq_pkg::CMD_DECRYPT) begin
          kidx = 6'(6'd15 - 6'(Base + j));
          x    = kq_pkg::dec_round(x, key_i[kidx]);
        end else begin
          kidx = 6'(Base + j);
          x    = kq_pkg::enc_round(x, key_i[kidx]);
        end
      end
    end
    word_d         = word_i;
    word_d.data    = x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      command_q <= word_d.command;
      data_q    <= word_d.data;
    end
  end

  assign word_o = '{valid: valid_q, command: command_q, data: data_q};

endmodule
